/* src/line_table_program_encoder_top_assert.svh */
// Assertion macros shared by the line table program encoder RTL
`ifndef LINE_TABLE_PROGRAM_ENCODER_TOP_ASSERT_SVH
`define LINE_TABLE_PROGRAM_ENCODER_TOP_ASSERT_SVH

// condition that must hold at every clock out of reset
`define LTPE_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define LTPE_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence in the following cycle
`define LTPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ltpe_pkg.sv */
// Shared constants and codes for the line table program encoder
`timescale 1ns / 1ps

package ltpe_pkg;

  // widths of the transaction fields
  localparam int CMD_W  = 2;
  localparam int LINE_W = 32;
  localparam int ADDR_W = 32;
  localparam int BYTE_W = 8;

  // bytes written by set_address
  localparam int ADDR_BYTES = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPAN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPECIAL = 1'b1;
  localparam logic [CFG_DATA_W-1:0] LINE_SPAN_RST     = 8'd8;
  localparam logic [CFG_DATA_W-1:0] FIRST_SPECIAL_RST = 8'd10;

  // input commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROW   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // standard and extended opcodes
  localparam logic [BYTE_W-1:0] OP_EXTENDED     = 8'd0;
  localparam logic [BYTE_W-1:0] OP_COPY         = 8'd1;
  localparam logic [BYTE_W-1:0] OP_ADVANCE_PC   = 8'd2;
  localparam logic [BYTE_W-1:0] OP_ADVANCE_LINE = 8'd3;
  localparam logic [BYTE_W-1:0] OP_NEGATE_STMT  = 8'd6;
  localparam logic [BYTE_W-1:0] OP_END_SEQUENCE = 8'd1;
  localparam logic [BYTE_W-1:0] OP_SET_ADDRESS  = 8'd2;
  localparam logic [BYTE_W-1:0] END_SEQ_LEN     = 8'd1;
  localparam logic [BYTE_W-1:0] SET_ADDR_LEN    = BYTE_W'(ADDR_BYTES + 1);

  // emission phases, in output order; one flag bit each
  localparam int PH_N = 8;
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_AL0  = 3'd0;
  localparam logic [PH_W-1:0] PH_SA   = 3'd1;
  localparam logic [PH_W-1:0] PH_NEG  = 3'd2;
  localparam logic [PH_W-1:0] PH_SPEC = 3'd3;
  localparam logic [PH_W-1:0] PH_PC   = 3'd4;
  localparam logic [PH_W-1:0] PH_AL   = 3'd5;
  localparam logic [PH_W-1:0] PH_COPY = 3'd6;
  localparam logic [PH_W-1:0] PH_END  = 3'd7;

  // byte counter inside a phase: set_address or a LEB128 operand with opcode
  localparam int SA_LEN   = ADDR_BYTES + 3;
  localparam int LEB_LEN  = 6;
  localparam int SEQ_MAX  = (SA_LEN > LEB_LEN) ? SA_LEN : LEB_LEN;
  localparam int CNT_W    = $clog2(SEQ_MAX);
  localparam logic [CNT_W-1:0] SA_LAST = CNT_W'(SA_LEN - 1);
  localparam int SA_W     = ADDR_BYTES * 8;

endpackage

/* src/ltpe_in_if.sv */
// Input channel: command, line and address with valid/ready
`timescale 1ns / 1ps

interface ltpe_in_if;
  import ltpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LINE_W-1:0] line;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output line, output address, input ready);
  modport sink   (input valid, input command, input line, input address, output ready);
endinterface

/* src/ltpe_out_if.sv */
// Result channel: one program byte and its last marker with valid/ready
`timescale 1ns / 1ps

interface ltpe_out_if;
  import ltpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

/* src/line_table_program_encoder_top.sv */
// Line table program encoder: rows in, line-number-program bytes out
`timescale 1ns / 1ps

// Turns start, row and end commands into line-number-program bytes, one byte
// per output transaction, with last_byte on the final byte of each command.
// Work per command is done by a small sequencer around one shared 32-bit
// subtractor and one 8x8 multiplier: line delta, address delta, special
// opcode product and plan are registered steps in that order, then the bytes
// leave one after another from the output register, each held there until
// out_ch.ready takes it. A command giving N bytes holds in_ch.ready low from
// acceptance until its final byte is loaded into the output register (until
// the plan step for a command giving no bytes); output stalls add to that.
// N is 1 for most rows and at most 15. The next command is taken
// while the final byte still waits in the output register.

`include "line_table_program_encoder_top_assert.svh"

module line_table_program_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ltpe_in_if.sink                         in_ch,
  ltpe_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ltpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ltpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ltpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DL,
    S_DA,
    S_MUL,
    S_PLAN,
    S_EMIT
  } state_t;

  // control registers
  state_t                state_r, state_nxt;
  logic [PH_N-1:0]       flags_r, flags_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [LINE_W-1:0]     cur_line_r, cur_line_nxt;
  logic [ADDR_W-1:0]     cur_addr_r, cur_addr_nxt;
  logic [CFG_DATA_W-1:0] span_r, span_nxt;
  logic [CFG_DATA_W-1:0] fso_r, fso_nxt;

  // payload registers
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [LINE_W-1:0]     line_r, line_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [LINE_W-1:0]     dl_r, dl_nxt;
  logic [ADDR_W-1:0]     da_r, da_nxt;
  logic                  back_r, back_nxt;
  logic [15:0]           prod_r, prod_nxt;
  logic [BYTE_W-1:0]     spec_r, spec_nxt;
  logic [LINE_W-1:0]     al_v_r, al_v_nxt;
  logic [ADDR_W-1:0]     pc_v_r, pc_v_nxt;
  logic [SA_W-1:0]       sa_sh_r, sa_sh_nxt;

  // shared subtractor
  logic [ADDR_W-1:0]     sub_a, sub_b;
  logic [ADDR_W:0]       sub_res;

  // planning terms
  logic                  dl_in_span, op_ok, da_hi;
  logic [16:0]           op_sum;

  // emission terms
  logic [PH_W-1:0]       cur_ph;
  logic [BYTE_W-1:0]     emit_byte;
  logic                  emit_done, emit_last, emit_go, slot_free;
  logic [LINE_W-1:0]     sl_next;
  logic                  sl_done;
  logic [ADDR_W-1:0]     ul_next;
  logic                  ul_done;
  logic [PH_N-1:0]       flags_left;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit_go   = (state_r == S_EMIT) && slot_free;

  // one subtractor: line delta first, address delta next; borrow is "backwards"
  always_comb begin
    if (state_r == S_DA) begin
      sub_a = addr_r;
      sub_b = cur_addr_r;
    end else begin
      sub_a = line_r;
      sub_b = (cmd_r == CMD_START) ? 32'd1 : cur_line_r;
    end
    sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  end

  // special opcode candidate
  always_comb begin
    da_hi      = |da_r[ADDR_W-1:8];
    dl_in_span = (dl_r[LINE_W-1:8] == '0) && (dl_r[7:0] != 8'd0) && (dl_r[7:0] < span_r);
    op_sum     = 17'({dl_r[7:0]} - 8'd1) + 17'(prod_r) + 17'(fso_r);
    op_ok      = !da_hi && (op_sum < 17'd256);
  end

  // current phase is the lowest pending flag
  always_comb begin
    cur_ph = PH_END;
    for (int i = PH_N - 1; i >= 0; i--) begin
      if (flags_r[i]) cur_ph = PH_W'(i);
    end
  end

  // LEB128 steps
  always_comb begin
    sl_next = {{7{al_v_r[LINE_W-1]}}, al_v_r[LINE_W-1:7]};
    sl_done = ((sl_next == '0) && !al_v_r[6]) || ((sl_next == '1) && al_v_r[6]);
    ul_next = pc_v_r >> 7;
    ul_done = (ul_next == '0);
  end

  // byte of the current phase
  always_comb begin
    emit_byte = OP_COPY;
    emit_done = 1'b1;
    case (cur_ph)
      PH_AL0, PH_AL: begin
        if (cnt_r == '0) begin
          emit_byte = OP_ADVANCE_LINE;
          emit_done = 1'b0;
        end else begin
          emit_byte = {!sl_done, al_v_r[6:0]};
          emit_done = sl_done;
        end
      end
      PH_PC: begin
        if (cnt_r == '0) begin
          emit_byte = OP_ADVANCE_PC;
          emit_done = 1'b0;
        end else begin
          emit_byte = {!ul_done, pc_v_r[6:0]};
          emit_done = ul_done;
        end
      end
      PH_SA: begin
        emit_done = (cnt_r == SA_LAST);
        if (cnt_r == CNT_W'(0))      emit_byte = OP_EXTENDED;
        else if (cnt_r == CNT_W'(1)) emit_byte = SET_ADDR_LEN;
        else if (cnt_r == CNT_W'(2)) emit_byte = OP_SET_ADDRESS;
        else                         emit_byte = sa_sh_r[7:0];
      end
      PH_NEG:  emit_byte = OP_NEGATE_STMT;
      PH_SPEC: emit_byte = spec_r;
      PH_COPY: emit_byte = OP_COPY;
      PH_END: begin
        emit_done = (cnt_r == CNT_W'(2));
        if (cnt_r == CNT_W'(0))      emit_byte = OP_EXTENDED;
        else if (cnt_r == CNT_W'(1)) emit_byte = END_SEQ_LEN;
        else                         emit_byte = OP_END_SEQUENCE;
      end
      default: begin
        emit_byte = OP_COPY;
        emit_done = 1'b1;
      end
    endcase
    flags_left = flags_r & ~(PH_N'(1) << cur_ph);
    emit_last  = emit_done && (flags_left == '0);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    cur_line_nxt  = cur_line_r;
    cur_addr_nxt  = cur_addr_r;
    span_nxt      = span_r;
    fso_nxt       = fso_r;
    cmd_nxt       = cmd_r;
    line_nxt      = line_r;
    addr_nxt      = addr_r;
    dl_nxt        = dl_r;
    da_nxt        = da_r;
    back_nxt      = back_r;
    prod_nxt      = prod_r;
    spec_nxt      = spec_r;
    al_v_nxt      = al_v_r;
    pc_v_nxt      = pc_v_r;
    sa_sh_nxt     = sa_sh_r;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_SPAN:     span_nxt = cfg_wdata;
        CFG_FIRST_SPECIAL: fso_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          line_nxt  = in_ch.line;
          addr_nxt  = in_ch.address;
          state_nxt = S_DL;
        end
      end
      S_DL: begin
        dl_nxt    = sub_res[LINE_W-1:0];
        state_nxt = S_DA;
      end
      S_DA: begin
        back_nxt  = sub_res[ADDR_W];
        da_nxt    = sub_res[ADDR_W] ? '0 : sub_res[ADDR_W-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = {8'd0, span_r} * {8'd0, da_r[7:0]};
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        flags_nxt = '0;
        cnt_nxt   = '0;
        spec_nxt  = op_sum[7:0];
        al_v_nxt  = dl_r;
        pc_v_nxt  = da_r;
        sa_sh_nxt = SA_W'(addr_r);
        case (cmd_r)
          CMD_START: begin
            flags_nxt[PH_AL0]  = 1'b1;
            flags_nxt[PH_SA]   = 1'b1;
            flags_nxt[PH_NEG]  = 1'b1;
            flags_nxt[PH_COPY] = 1'b1;
            cur_line_nxt       = line_r;
            cur_addr_nxt       = addr_r;
          end
          CMD_ROW: begin
            flags_nxt[PH_SA]   = back_r;
            flags_nxt[PH_SPEC] = dl_in_span && op_ok;
            flags_nxt[PH_PC]   = !back_r && ((dl_in_span && !op_ok) ||
                                 (!dl_in_span && ((dl_r != '0) || (da_r != '0))));
            flags_nxt[PH_AL]   = (dl_in_span && !op_ok) || (!dl_in_span && (dl_r != '0));
            flags_nxt[PH_COPY] = (dl_in_span && !op_ok) ||
                                 (!dl_in_span && ((dl_r != '0) || back_r || (da_r != '0)));
            cur_line_nxt       = line_r;
            cur_addr_nxt       = addr_r;
          end
          CMD_END: begin
            flags_nxt[PH_SA]   = 1'b1;
            flags_nxt[PH_COPY] = 1'b1;
            flags_nxt[PH_END]  = 1'b1;
          end
          default: ;
        endcase
        state_nxt = (flags_nxt == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_byte;
          out_last_nxt  = emit_last;
          cnt_nxt       = emit_done ? '0 : cnt_r + CNT_W'(1);
          if (cnt_r != '0) begin
            if (cur_ph == PH_AL0 || cur_ph == PH_AL) al_v_nxt = sl_next;
            if (cur_ph == PH_PC)                     pc_v_nxt = ul_next;
          end
          if (cur_ph == PH_SA && cnt_r > CNT_W'(2)) sa_sh_nxt = sa_sh_r >> 8;
          if (emit_done) flags_nxt = flags_left;
          if (emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      out_last_r  <= 1'b0;
      cur_line_r  <= '0;
      cur_addr_r  <= '0;
      span_r      <= LINE_SPAN_RST;
      fso_r       <= FIRST_SPECIAL_RST;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_byte_r  <= out_byte_nxt;
      out_last_r  <= out_last_nxt;
      cur_line_r  <= cur_line_nxt;
      cur_addr_r  <= cur_addr_nxt;
      span_r      <= span_nxt;
      fso_r       <= fso_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    line_r  <= line_nxt;
    addr_r  <= addr_nxt;
    dl_r    <= dl_nxt;
    da_r    <= da_nxt;
    back_r  <= back_nxt;
    prod_r  <= prod_nxt;
    spec_r  <= spec_nxt;
    al_v_r  <= al_v_nxt;
    pc_v_r  <= pc_v_nxt;
    sa_sh_r <= sa_sh_nxt;
  end

  // checks
  `LTPE_ASSERT_IMPLY(a_emit_has_work, state_r == S_EMIT, flags_r != '0, "emitting with no phase pending")
  `LTPE_ASSERT_NEXT(a_last_goes_idle, emit_go && emit_last, state_r == S_IDLE && out_valid_r && out_last_r, "final byte did not end the command")
  `LTPE_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == S_DL, "accepted transaction did not start the sequencer")
  `LTPE_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= SA_LAST || cnt_r < CNT_W'(LEB_LEN), "phase byte counter out of range")

endmodule

/* tb/tb_line_table_program_encoder_top.sv */
// Testbench for the line table program encoder: directed and random rows against a line-program predictor
`timescale 1ns / 1ps

module tb_line_table_program_encoder_top;
  import ltpe_pkg::*;

  // command code the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ROWS_PER_PHASE = 33;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [LINE_W-1:0] line;
    logic [ADDR_W-1:0] addr;
  } row_cmd_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              last;
  } prog_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ltpe_in_if  in_ch();
  ltpe_out_if out_ch();

  line_table_program_encoder_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // stimulus and expectations
  row_cmd_t   cmd_fifo[$];
  prog_byte_t prog_q[$];
  logic [BYTE_W-1:0] new_bytes[$];

  // predictor copy of the row state and registers
  logic [LINE_W-1:0] row_line;
  logic [ADDR_W-1:0] row_addr;
  logic [7:0] span_reg;
  logic [7:0] fso_reg;

  int  err_cnt = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  idle_off = 1'b0;
  logic in_fire_q = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    err_cnt++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------- line program predictor ----------------
  function automatic void emit(input logic [BYTE_W-1:0] b);
    new_bytes.push_back(b);
  endfunction

  function automatic void put_uleb(input logic [31:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      emit(b);
    end while (v != 0);
  endfunction

  function automatic void put_sleb(input logic [31:0] v);
    logic neg;
    logic [7:0] b;
    bit done;
    neg = v[31];
    done = 1'b0;
    while (!done) begin
      b = {1'b0, v[6:0]};
      v = {{7{neg}}, v[31:7]};
      if ((v == 32'd0 && !b[6]) || (v == 32'hFFFF_FFFF && b[6])) begin
        emit(b);
        done = 1'b1;
      end else begin
        emit(b | 8'h80);
      end
    end
  endfunction

  function automatic void put_set_address(input logic [31:0] a);
    emit(OP_EXTENDED);
    emit(SET_ADDR_LEN);
    emit(OP_SET_ADDRESS);
    for (int i = 0; i < ADDR_BYTES; i++) emit(i < 4 ? a[8*i +: 8] : 8'h00);
  endfunction

  function automatic void put_advance_pc(input logic [31:0] da);
    emit(OP_ADVANCE_PC);
    put_uleb(da);
  endfunction

  function automatic void put_advance_line(input logic [31:0] dl);
    emit(OP_ADVANCE_LINE);
    put_sleb(dl);
  endfunction

  function automatic void encode_row(input logic [31:0] ln, input logic [31:0] ad);
    logic [31:0] dl;
    logic back;
    logic in_span;
    logic [63:0] da;
    logic [63:0] op;
    dl = ln - row_line;
    back = ad < row_addr;
    da = back ? 64'd0 : {32'd0, ad - row_addr};
    in_span = !dl[31] && dl >= 32'd1 && {32'd0, dl} < {56'd0, span_reg};
    if (back) put_set_address(ad);
    if (in_span) begin
      op = {32'd0, dl - 32'd1} + {56'd0, span_reg} * da + {56'd0, fso_reg};
      if (op < 64'd256) begin
        emit(op[7:0]);
      end else begin
        if (!back) put_advance_pc(da[31:0]);
        put_advance_line(dl);
        emit(OP_COPY);
      end
    end else if (dl != 0) begin
      if (!back) put_advance_pc(da[31:0]);
      put_advance_line(dl);
      emit(OP_COPY);
    end else if (back) begin
      emit(OP_COPY);
    end else if (da != 0) begin
      put_advance_pc(da[31:0]);
      emit(OP_COPY);
    end
    row_line = ln;
    row_addr = ad;
  endfunction

  // expected bytes for one accepted command
  function automatic void encode_command(input logic [CMD_W-1:0] c, input logic [31:0] ln,
                                         input logic [31:0] ad);
    prog_byte_t e;
    case (c)
      CMD_START: begin
        put_advance_line(ln - 32'd1);
        put_set_address(ad);
        emit(OP_NEGATE_STMT);
        emit(OP_COPY);
        row_line = ln;
        row_addr = ad;
      end
      CMD_ROW: encode_row(ln, ad);
      CMD_END: begin
        put_set_address(ad);
        emit(OP_COPY);
        emit(OP_EXTENDED);
        emit(END_SEQ_LEN);
        emit(OP_END_SEQUENCE);
      end
      default: ;
    endcase
    foreach (new_bytes[i]) begin
      e.b = new_bytes[i];
      e.last = (i == new_bytes.size() - 1);
      prog_q.push_back(e);
    end
    new_bytes.delete();
  endfunction

  // ---------------- input driver ----------------
  always @(negedge clk) begin
    row_cmd_t nxt;
    if (rst_n) begin
      if (!in_ch.valid || in_fire_q) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (cmd_fifo.size() > 0) begin
          nxt = cmd_fifo.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.command <= nxt.cmd;
          in_ch.line    <= nxt.line;
          in_ch.address <= nxt.addr;
          in_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall = out_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  // ---------------- monitor: predict on input, check on output ----------------
  always @(posedge clk) begin
    prog_byte_t e;
    in_fire_q = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire_q) encode_command(in_ch.command, in_ch.line, in_ch.address);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (prog_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
      end else begin
        e = prog_q.pop_front();
        if (out_ch.out_byte !== e.b)
          flag_mismatch($sformatf("out_byte %02h, expected %02h", out_ch.out_byte, e.b));
        if (out_ch.last_byte !== e.last)
          flag_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                  out_ch.last_byte, e.last, e.b));
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic add_item(input logic [CMD_W-1:0] c, input logic [31:0] l,
                          input logic [31:0] a);
    row_cmd_t it;
    it.cmd = c;
    it.line = l;
    it.addr = a;
    cmd_fifo.push_back(it);
  endtask

  // next row of a well-formed sequence: mostly small forward steps
  task automatic next_row(inout logic [31:0] ln, inout logic [31:0] ad);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) ln = ln + $urandom_range(1, 12);
    else if (r < 75) ln = ln;
    else if (r < 90) ln = ln - $urandom_range(1, 50);
    else ln = $urandom;
    r = $urandom_range(0, 99);
    if (r < 60) ad = ad + $urandom_range(0, 40);
    else if (r < 70) ad = ad;
    else if (r < 85) ad = ad - $urandom_range(1, 100);
    else ad = ad + $urandom;
  endtask

  task automatic add_random_phase(input int n);
    int made;
    int k;
    logic [CMD_W-1:0] c;
    logic [31:0] ln;
    logic [31:0] ad;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 80) begin
        ln = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000);
        ad = $urandom;
        add_item(CMD_START, ln, ad);
        k = $urandom_range(1, 8);
        repeat (k) begin
          next_row(ln, ad);
          add_item(CMD_ROW, ln, ad);
        end
        made += k + 1;
        // now and then the sequence is left open
        if ($urandom_range(0, 9) != 0) begin
          add_item(CMD_END, $urandom, ad + $urandom_range(0, 64));
          made++;
        end
      end else begin
        c = CMD_W'($urandom_range(0, 3));
        add_item(c, $urandom, $urandom);
        if (c != CMD_UNUSED) made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_fifo.size() != 0 || in_ch.valid || prog_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LINE_SPAN) span_reg = val;
    else fso_reg = val;
  endtask

  // ---------------- main sequence ----------------
  initial begin
    logic [7:0] span_v;
    logic [7:0] fso_v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LINE_SPAN;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_START;
    in_ch.line = '0;
    in_ch.address = '0;
    out_ch.ready = 1'b0;
    row_line = '0;
    row_addr = '0;
    span_reg = LINE_SPAN_RST;
    fso_reg = FIRST_SPECIAL_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: row before any start, start extremes, each row encoding
    add_item(CMD_ROW, 32'd5, 32'h10);
    add_item(CMD_START, 32'd0, 32'd0);
    add_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_END, 32'd0, 32'hFFFF_FFFF);
    add_item(CMD_START, 32'd1, 32'h1000);
    add_item(CMD_ROW, 32'd1, 32'h1000);          // unchanged row
    add_item(CMD_ROW, 32'd2, 32'h1000);          // special, no address step
    add_item(CMD_ROW, 32'd9, 32'h1001);          // top of the special line range
    add_item(CMD_ROW, 32'd17, 32'h1001);         // line step equal to span
    add_item(CMD_ROW, 32'd17, 32'h1005);         // address only
    add_item(CMD_ROW, 32'd10, 32'h1005);         // line goes back
    add_item(CMD_ROW, 32'd10, 32'h1000);         // address back, same line
    add_item(CMD_ROW, 32'd12, 32'h0F00);         // address back, special line step
    add_item(CMD_ROW, 32'd1000, 32'h0E00);       // address back, large line step
    add_item(CMD_ROW, 32'd1001, 32'h0F00);       // special overflows 255
    add_item(CMD_ROW, 32'd1001 + 32'h8000_0000, 32'hFFFF_FFFF);
    add_item(CMD_ROW, 32'd1001 + 32'h8000_0000 + 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_ROW, 32'd0, 32'd0);
    add_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_ROW, 32'd1, 32'd0);
    add_item(CMD_END, 32'hFFFF_FFFF, 32'h2000);
    add_item(CMD_ROW, 32'd2, 32'd1);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin span_v = 8'd1;   fso_v = 8'd1;   end
        1: begin span_v = 8'd255; fso_v = 8'd255; end
        2: begin span_v = 8'd0;   fso_v = 8'd128; end
        3: begin span_v = 8'd2;   fso_v = 8'd250; end
        4: begin span_v = 8'd16;  fso_v = 8'd0;   end
        7: begin span_v = LINE_SPAN_RST; fso_v = FIRST_SPECIAL_RST; end
        default: begin
          span_v = 8'($urandom_range(1, 255));
          fso_v = 8'($urandom_range(1, 255));
        end
      endcase
      write_reg(CFG_LINE_SPAN, span_v);
      write_reg(CFG_FIRST_SPECIAL, fso_v);
      idle_off = ($urandom_range(0, 3) == 0);
      add_random_phase(ROWS_PER_PHASE);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    repeat (30) @(posedge clk);
    if (err_cnt == 0 && prog_q.size() == 0) begin
      $display("tb_line_table_program_encoder_top: PASS");
    end else begin
      $display("tb_line_table_program_encoder_top: FAIL");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #2_000_000;
    $display("tb_line_table_program_encoder_top: FAIL");
    $finish;
  end

endmodule
